// ----- hdl/fcl_pkg.sv -----
package fcl_pkg;

  // list geometry
  localparam int CAPACITY    = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [IDX_W-1:0]       slot_idx_t;

  // command codes
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_REM_VAL = 3'd2,
    CMD_REM_AT  = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_READ    = 3'd5,
    CMD_WRITE   = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_code_t;

  // what a cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     in_use;
  } cell_ctl_t;

  // command beat
  typedef struct packed {
    cmd_code_t   cmd;
    logic [2:0]  slot_index;
    logic [31:0] item_value;
  } cmd_beat_t;

  // response beat
  typedef struct packed {
    logic        ok;
    logic        found;
    logic [2:0]  position;
    logic [31:0] read_value;
    logic [3:0]  item_count;
  } rsp_beat_t;

endpackage

// ----- hdl/fcl_cell.sv -----
module fcl_cell (
  input  logic              clk,
  input  logic              rst,
  input  fcl_pkg::cell_ctl_t ctl,
  input  fcl_pkg::value_t   item_value,
  input  fcl_pkg::value_t   left_val,
  input  fcl_pkg::value_t   right_val,
  output fcl_pkg::value_t   slot_val,
  output logic              hit
);

  // slot register, loaded or shifted from a neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_val <= '0;
    end else begin
      case (ctl.op)
        fcl_pkg::CELL_LOAD:       slot_val <= item_value;
        fcl_pkg::CELL_FROM_LEFT:  slot_val <= left_val;
        fcl_pkg::CELL_FROM_RIGHT: slot_val <= right_val;
        default:                  slot_val <= slot_val;
      endcase
    end
  end

  // compare against the broadcast value, only inside the list
  assign hit = ctl.in_use && (slot_val == item_value);

endmodule

// ----- hdl/fcl_first_match.sv -----
module fcl_first_match (
  input  logic [fcl_pkg::CAPACITY-1:0] hits,
  output logic                         any_hit,
  output fcl_pkg::slot_idx_t           hit_pos
);

  // lowest set bit wins
  always_comb begin
    hit_pos = '0;
    for (int k = fcl_pkg::CAPACITY - 1; k >= 0; k--) begin
      if (hits[k]) begin
        hit_pos = fcl_pkg::IDX_W'(k);
      end
    end
  end

  assign any_hit = |hits;

endmodule

// ----- hdl/fixed_capacity_list_engine_top.sv -----
// response: registered, valid in the cycle after its command beat is accepted
// throughput: one command per cycle while cmd_stall is low; every cell compares and shifts in parallel,
//   so the single response register is the only thing that paces the block
// reset: synchronous, clears the entry count, every slot and the response valid
// cmd_stall is high only while a response waits under rsp_stall
module fixed_capacity_list_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  fcl_pkg::cmd_beat_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output fcl_pkg::rsp_beat_t rsp
);

  fcl_pkg::count_t    used_count;
  fcl_pkg::count_t    used_count_next;
  fcl_pkg::rsp_beat_t rsp_next;

  fcl_pkg::value_t    slot_vals  [fcl_pkg::CAPACITY];
  fcl_pkg::value_t    left_vals  [fcl_pkg::CAPACITY];
  fcl_pkg::value_t    right_vals [fcl_pkg::CAPACITY];
  fcl_pkg::cell_ctl_t ctl        [fcl_pkg::CAPACITY];
  logic [fcl_pkg::CAPACITY-1:0] hits;

  fcl_pkg::value_t    key;
  fcl_pkg::count_t    idx_ext;
  fcl_pkg::count_t    gap_ext;
  fcl_pkg::slot_idx_t idx;
  fcl_pkg::slot_idx_t hit_pos;
  logic               any_hit;
  logic               accept;
  logic               do_add;
  logic               do_insert;
  logic               do_close;
  logic               do_write;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  assign key     = fcl_pkg::VALUE_WIDTH'(cmd.item_value);
  assign idx     = fcl_pkg::IDX_W'(cmd.slot_index);
  assign idx_ext = fcl_pkg::CNT_W'(cmd.slot_index);

  // row of slot cells
  for (genvar i = 0; i < fcl_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_vals[i] = '0;
    end else begin : g_mid
      assign left_vals[i] = slot_vals[i-1];
    end
    if (i == fcl_pkg::CAPACITY - 1) begin : g_last
      assign right_vals[i] = '0;
    end else begin : g_inner
      assign right_vals[i] = slot_vals[i+1];
    end

    // per-cell move decision
    always_comb begin
      ctl[i].in_use = fcl_pkg::CNT_W'(i) < used_count;
      ctl[i].op     = fcl_pkg::CELL_HOLD;
      if (do_add && fcl_pkg::CNT_W'(i) == used_count) begin
        ctl[i].op = fcl_pkg::CELL_LOAD;
      end else if (do_insert && fcl_pkg::CNT_W'(i) == idx_ext) begin
        ctl[i].op = fcl_pkg::CELL_LOAD;
      end else if (do_insert && fcl_pkg::CNT_W'(i) > idx_ext &&
                   fcl_pkg::CNT_W'(i) <= used_count) begin
        ctl[i].op = fcl_pkg::CELL_FROM_LEFT;
      end else if (do_close && fcl_pkg::CNT_W'(i) >= gap_ext &&
                   fcl_pkg::CNT_W'(i + 1) < used_count) begin
        ctl[i].op = fcl_pkg::CELL_FROM_RIGHT;
      end else if (do_write && fcl_pkg::CNT_W'(i) == idx_ext) begin
        ctl[i].op = fcl_pkg::CELL_LOAD;
      end
    end

    fcl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[i]),
      .item_value (key),
      .left_val   (left_vals[i]),
      .right_val  (right_vals[i]),
      .slot_val   (slot_vals[i]),
      .hit        (hits[i])
    );
  end

  fcl_first_match u_match (
    .hits    (hits),
    .any_hit (any_hit),
    .hit_pos (hit_pos)
  );

  // command decode and response
  always_comb begin
    rsp_next        = '0;
    used_count_next = used_count;
    do_add          = 1'b0;
    do_insert       = 1'b0;
    do_close        = 1'b0;
    do_write        = 1'b0;
    gap_ext         = idx_ext;
    case (cmd.cmd)
      fcl_pkg::CMD_ADD: begin
        rsp_next.ok = used_count < fcl_pkg::CNT_W'(fcl_pkg::CAPACITY);
        do_add      = accept && rsp_next.ok;
        if (rsp_next.ok) used_count_next = used_count + fcl_pkg::CNT_W'(1);
      end
      fcl_pkg::CMD_INSERT: begin
        rsp_next.ok = used_count < fcl_pkg::CNT_W'(fcl_pkg::CAPACITY) &&
                      idx_ext < used_count;
        do_insert   = accept && rsp_next.ok;
        if (rsp_next.ok) used_count_next = used_count + fcl_pkg::CNT_W'(1);
      end
      fcl_pkg::CMD_REM_VAL: begin
        rsp_next.ok       = any_hit;
        rsp_next.found    = any_hit;
        rsp_next.position = 3'(hit_pos);
        gap_ext           = fcl_pkg::CNT_W'(hit_pos);
        do_close          = accept && any_hit;
        if (any_hit) used_count_next = used_count - fcl_pkg::CNT_W'(1);
      end
      fcl_pkg::CMD_REM_AT: begin
        rsp_next.ok = idx_ext < used_count;
        do_close    = accept && rsp_next.ok;
        if (rsp_next.ok) used_count_next = used_count - fcl_pkg::CNT_W'(1);
      end
      fcl_pkg::CMD_FIND: begin
        rsp_next.ok       = 1'b1;
        rsp_next.found    = any_hit;
        rsp_next.position = 3'(hit_pos);
      end
      fcl_pkg::CMD_READ: begin
        rsp_next.ok = idx_ext < fcl_pkg::CNT_W'(fcl_pkg::CAPACITY);
        if (rsp_next.ok) rsp_next.read_value = 32'(slot_vals[idx]);
      end
      fcl_pkg::CMD_WRITE: begin
        rsp_next.ok = idx_ext < fcl_pkg::CNT_W'(fcl_pkg::CAPACITY);
        do_write    = accept && rsp_next.ok;
      end
      fcl_pkg::CMD_CLEAR: begin
        rsp_next.ok     = 1'b1;
        used_count_next = '0;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    rsp_next.item_count = 4'(used_count_next);
  end

  // count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        used_count <= used_count_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- hdl/fcl_checker.sv -----
module fcl_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input fcl_pkg::cmd_beat_t cmd,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input fcl_pkg::rsp_beat_t rsp
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.item_count <= 4'(fcl_pkg::CAPACITY))
    else $error("item count above capacity");

  // a hit is always a valid command
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.ok)
    else $error("found without ok");

  // position only reported with a hit
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.position == 3'd0)
    else $error("position set without a hit");

endmodule

bind fixed_capacity_list_engine_top fcl_checker u_fcl_checker (.*);

// ----- bench/fixed_capacity_list_engine_top_tb.sv -----
`timescale 1ns / 100ps

module fixed_capacity_list_engine_top_tb;

  logic               clk;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  fcl_pkg::cmd_beat_t cmd = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  fcl_pkg::rsp_beat_t rsp;

  // typed-in expectation that travels alongside the command beat
  bit                 pin_en = 1'b0;
  fcl_pkg::rsp_beat_t pin_rsp = '0;

  typedef struct {
    fcl_pkg::cmd_beat_t beat;
    bit                 pinned;
    fcl_pkg::rsp_beat_t want;
  } list_row_t;

  list_row_t          plan[$];
  fcl_pkg::rsp_beat_t rsp_expect_q[$];
  fcl_pkg::rsp_beat_t predicted;
  fcl_pkg::value_t    list_slots [fcl_pkg::CAPACITY];
  fcl_pkg::count_t    list_count;
  bit                 no_idle = 1'b0;
  int                 fails = 0;

  fixed_capacity_list_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // timeout
  initial begin
    #2_000_000;
    $display("fixed_capacity_list_engine_top_tb NOT OK");
    $finish;
  end

  // drop one entry and close the gap behind it
  function automatic void close_list_gap(int at);
    for (int i = at; i + 1 < list_count; i++)
      list_slots[i] = list_slots[i + 1];
    list_count = list_count - fcl_pkg::CNT_W'(1);
  endfunction

  // list behavior: applies one command and returns the response it causes
  function automatic fcl_pkg::rsp_beat_t apply_list_cmd(fcl_pkg::cmd_beat_t b);
    fcl_pkg::rsp_beat_t r;
    int                 hit;
    r = '0;
    hit = -1;
    for (int i = 0; i < list_count; i++)
      if (hit < 0 && list_slots[i] == b.item_value) hit = i;
    case (b.cmd)
      fcl_pkg::CMD_ADD: begin
        if (list_count < fcl_pkg::CAPACITY) begin
          list_slots[list_count] = b.item_value;
          list_count = list_count + fcl_pkg::CNT_W'(1);
          r.ok = 1'b1;
        end
      end
      fcl_pkg::CMD_INSERT: begin
        if (list_count < fcl_pkg::CAPACITY && b.slot_index < list_count) begin
          for (int i = list_count; i > b.slot_index; i--)
            list_slots[i] = list_slots[i - 1];
          list_slots[b.slot_index] = b.item_value;
          list_count = list_count + fcl_pkg::CNT_W'(1);
          r.ok = 1'b1;
        end
      end
      fcl_pkg::CMD_REM_VAL: begin
        if (hit >= 0) begin
          close_list_gap(hit);
          r.ok = 1'b1;
          r.found = 1'b1;
          r.position = hit[2:0];
        end
      end
      fcl_pkg::CMD_REM_AT: begin
        if (b.slot_index < list_count) begin
          close_list_gap(b.slot_index);
          r.ok = 1'b1;
        end
      end
      fcl_pkg::CMD_FIND: begin
        r.ok = 1'b1;
        if (hit >= 0) begin
          r.found = 1'b1;
          r.position = hit[2:0];
        end
      end
      fcl_pkg::CMD_READ: begin
        r.ok = 1'b1;
        r.read_value = list_slots[b.slot_index];
      end
      fcl_pkg::CMD_WRITE: begin
        list_slots[b.slot_index] = b.item_value;
        r.ok = 1'b1;
      end
      default: begin
        list_count = '0;
        r.ok = 1'b1;
      end
    endcase
    r.item_count = list_count;
    return r;
  endfunction

  // field-by-field comparison of one response beat
  task automatic check_rsp(fcl_pkg::rsp_beat_t want, fcl_pkg::rsp_beat_t got);
    if (got.ok !== want.ok) begin
      $error("ok: expected %0d, got %0d", want.ok, got.ok);
      fails++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      fails++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      fails++;
    end
    if (got.read_value !== want.read_value) begin
      $error("read_value: expected %08h, got %08h", want.read_value, got.read_value);
      fails++;
    end
    if (got.item_count !== want.item_count) begin
      $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
      fails++;
    end
  endtask

  // monitor: check responses, then predict for accepted commands
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_expect_q.size() == 0) begin
          $error("response beat with nothing outstanding");
          fails++;
        end else begin
          check_rsp(rsp_expect_q.pop_front(), rsp);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        predicted = apply_list_cmd(cmd);
        rsp_expect_q.push_back(pin_en ? pin_rsp : predicted);
      end
    end
  end

  // response side: random stall before each beat
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  task automatic send_cmd(fcl_pkg::cmd_beat_t b, bit pin, fcl_pkg::rsp_beat_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= b;
    pin_en <= pin;
    pin_rsp <= want;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic plan_row(fcl_pkg::cmd_code_t c, int idx, logic [31:0] v, bit pin,
                          bit ok, bit found, int pos, logic [31:0] rd, int cnt);
    list_row_t row;
    row.beat.cmd = c;
    row.beat.slot_index = idx[2:0];
    row.beat.item_value = v;
    row.pinned = pin;
    row.want.ok = ok;
    row.want.found = found;
    row.want.position = pos[2:0];
    row.want.read_value = rd;
    row.want.item_count = cnt[3:0];
    plan.push_back(row);
  endtask

  // small set of values so that finds and removes often match
  function automatic logic [31:0] pool_value(int k);
    case (k)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      4: return 32'h1234_5678;
      5: return 32'h0000_0005;
      6: return 32'hA5A5_A5A5;
      default: return 32'h5A5A_5A5A;
    endcase
  endfunction

  // stimulus
  initial begin
    fcl_pkg::cmd_beat_t b;
    int                 sel;
    for (int i = 0; i < fcl_pkg::CAPACITY; i++) list_slots[i] = '0;
    list_count = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, fill to capacity, refusals, shifts, clear
    plan_row(fcl_pkg::CMD_READ,    7, 32'h0,         1, 1, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_REM_AT,  0, 32'h0,         1, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_INSERT,  0, 32'h1,         1, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_FIND,    0, 32'h0,         1, 1, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_REM_VAL, 0, 32'h0,         1, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'hFFFF_FFFF, 1, 1, 0, 0, 32'h0, 1);
    plan_row(fcl_pkg::CMD_ADD,     7, 32'h0,         1, 1, 0, 0, 32'h0, 2);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'h8000_0000, 1, 1, 0, 0, 32'h0, 3);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'h1234_5678, 1, 1, 0, 0, 32'h0, 4);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'h5,         1, 1, 0, 0, 32'h0, 5);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'hFFFF_FFFF, 1, 1, 0, 0, 32'h0, 6);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'h7,         1, 1, 0, 0, 32'h0, 7);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'hA5A5_A5A5, 1, 1, 0, 0, 32'h0, 8);
    plan_row(fcl_pkg::CMD_ADD,     0, 32'h9,         1, 0, 0, 0, 32'h0, 8);
    plan_row(fcl_pkg::CMD_INSERT,  0, 32'h9,         1, 0, 0, 0, 32'h0, 8);
    plan_row(fcl_pkg::CMD_FIND,    0, 32'hFFFF_FFFF, 1, 1, 1, 0, 32'h0, 8);
    plan_row(fcl_pkg::CMD_REM_VAL, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_FIND,    0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_REM_AT,  6, 32'h0,         0, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_INSERT,  5, 32'h3C,        0, 0, 0, 0, 32'h0, 0);
    // insert at the end of the list is refused
    plan_row(fcl_pkg::CMD_INSERT,  7, 32'h1,         0, 0, 0, 0, 32'h0, 0);
    // write and read above the count but inside capacity
    plan_row(fcl_pkg::CMD_WRITE,   7, 32'hDEAD_BEEF, 0, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_READ,    7, 32'h0,         0, 0, 0, 0, 32'h0, 0);
    plan_row(fcl_pkg::CMD_CLEAR,   0, 32'h0,         1, 1, 0, 0, 32'h0, 0);
    // clear keeps slot contents
    plan_row(fcl_pkg::CMD_READ,    3, 32'h0,         0, 0, 0, 0, 32'h0, 0);

    foreach (plan[i]) send_cmd(plan[i].beat, plan[i].pinned, plan[i].want);

    // random commands over a small value pool with some full-range values
    for (int n = 0; n < 1400; n++) begin
      no_idle = ((n / 100) % 4 == 3);
      if (n == 700) begin
        // hold off until the response side has drained
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (rsp_expect_q.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      b.cmd = sel < 24 ? fcl_pkg::CMD_ADD :
              sel < 40 ? fcl_pkg::CMD_INSERT :
              sel < 55 ? fcl_pkg::CMD_REM_VAL :
              sel < 70 ? fcl_pkg::CMD_REM_AT :
              sel < 82 ? fcl_pkg::CMD_FIND :
              sel < 90 ? fcl_pkg::CMD_READ :
              sel < 97 ? fcl_pkg::CMD_WRITE : fcl_pkg::CMD_CLEAR;
      b.slot_index = $urandom_range(0, 7);
      b.item_value = ($urandom_range(0, 9) < 7) ? pool_value($urandom_range(0, 7))
                                                : $urandom;
      send_cmd(b, 1'b0, '0);
    end
    no_idle = 1'b0;
    cmd_valid <= 1'b0;

    // drain and settle
    while (rsp_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("fixed_capacity_list_engine_top_tb OK");
    end else begin
      $display("fixed_capacity_list_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fcl_pkg.sv
hdl/fcl_cell.sv
hdl/fcl_first_match.sv
hdl/fixed_capacity_list_engine_top.sv
hdl/fcl_checker.sv
bench/fixed_capacity_list_engine_top_tb.sv
